// File: src/tfb_pkg.sv
// ============================================================================
// tfb_pkg
// Types, codes and byte helpers shared by the telemetry frame builder.
// ============================================================================
package tfb_pkg;

    // Action codes of an input word
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_DATA  = 1'b1;

    // Status codes of a result word
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DROPPED = 2'd1;
    localparam logic [1:0] ST_ABORTED = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_FORMAT  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ADDRESS = 8'd1;

    // Fixed frame bytes
    localparam logic [7:0] FLAG_BYTE = 8'h7e;
    localparam logic [7:0] END_BYTE  = 8'h0d;
    localparam logic [7:0] VER_FMT0  = 8'h90;
    localparam logic [7:0] VER_FMT1  = 8'h91;
    localparam logic [7:0] SUM_BUMP  = 8'h30;

    // Bytes ahead of the trailer in a header command: flag, version,
    // address bytes, two id bytes, two length bytes
    localparam logic [3:0] HDR_BYTES_FMT0 = 4'd10;
    localparam logic [3:0] HDR_BYTES_FMT1 = 4'd14;
    localparam logic [3:0] ADDR_START     = 4'd2;

    typedef struct packed {
        logic        action;
        logic [15:0] command_id;
        logic [15:0] payload_length;
        logic [7:0]  data_byte;
    } tfb_in_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       run_last;
        logic       frame_end;
        logic [1:0] status;
    } tfb_out_t;

    typedef enum logic [1:0] {
        CMD_HEADER  = 2'd0,
        CMD_PAYLOAD = 2'd1,
        CMD_DROP    = 2'd2
    } tfb_kind_t;

    // Classified word handed from the front to the back
    typedef struct packed {
        tfb_kind_t   kind;
        logic [1:0]  status;
        logic        fmt;
        logic        trailer;
        logic [15:0] command_id;
        logic [15:0] payload_length;
        logic [7:0]  data_byte;
        logic [7:0]  checksum;
    } tfb_cmd_t;

    // Final checksum byte: xor plus one, pushed off reserved byte values
    function automatic logic [7:0] finish_sum(input logic [7:0] x);
        logic [7:0] c;
        c = x + 8'd1;
        if (c inside {8'h00, 8'h7e, 8'h08, 8'h0a, 8'h0d, 8'h22}) begin
            c = c + SUM_BUMP;
        end
        return c;
    endfunction

    // XOR of all counted header bytes (version through length)
    function automatic logic [7:0] header_xor(
        input logic        fmt,
        input logic [63:0] addr,
        input logic [15:0] cid,
        input logic [15:0] len
    );
        logic [7:0] x;
        x = fmt ? VER_FMT1 : VER_FMT0;
        for (int i = 0; i < 4; i++) begin
            x = x ^ addr[8*i +: 8];
        end
        if (fmt) begin
            for (int i = 4; i < 8; i++) begin
                x = x ^ addr[8*i +: 8];
            end
        end
        x = x ^ cid[15:8] ^ cid[7:0] ^ len[15:8] ^ len[7:0];
        return x;
    endfunction

endpackage

// File: src/tfb_front.sv
// ============================================================================
// tfb_front
// Accepts input words, tracks the open frame and the running checksum, and
// turns each word into one command for the back end.
// ============================================================================
module tfb_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tfb_pkg::tfb_in_t  s_data,
    input  logic              frame_format,
    input  logic [63:0]       station_address,
    input  logic              q_ready,
    output logic              q_push,
    output tfb_pkg::tfb_cmd_t q_cmd
);
    import tfb_pkg::*;

    logic        open_reg, open_next;
    logic [15:0] remain_reg, remain_next;
    logic [7:0]  xor_reg, xor_next;
    logic [7:0]  hdr_x;
    logic [7:0]  pay_x;
    logic [15:0] remain_dec;

    assign s_ready = q_ready;
    assign q_push  = s_valid && q_ready;

    always_comb begin
        hdr_x       = header_xor(frame_format, station_address,
                                 s_data.command_id, s_data.payload_length);
        pay_x       = xor_reg ^ s_data.data_byte;
        remain_dec  = remain_reg - 16'd1;
        open_next   = open_reg;
        remain_next = remain_reg;
        xor_next    = xor_reg;

        q_cmd                = '0;
        q_cmd.fmt            = frame_format;
        q_cmd.command_id     = s_data.command_id;
        q_cmd.payload_length = s_data.payload_length;
        q_cmd.data_byte      = s_data.data_byte;

        if (s_data.action == ACT_START) begin
            q_cmd.kind     = CMD_HEADER;
            q_cmd.status   = open_reg ? ST_ABORTED : ST_OK;
            q_cmd.trailer  = (s_data.payload_length == 16'd0);
            q_cmd.checksum = finish_sum(hdr_x);
            open_next      = (s_data.payload_length != 16'd0);
            remain_next    = s_data.payload_length;
            xor_next       = (s_data.payload_length != 16'd0) ? hdr_x : 8'd0;
        end else if (!open_reg) begin
            q_cmd.kind      = CMD_DROP;
            q_cmd.status    = ST_DROPPED;
            q_cmd.data_byte = 8'd0;
        end else begin
            q_cmd.kind     = CMD_PAYLOAD;
            q_cmd.status   = ST_OK;
            q_cmd.trailer  = (remain_dec == 16'd0);
            q_cmd.checksum = finish_sum(pay_x);
            if (remain_dec == 16'd0) begin
                open_next   = 1'b0;
                remain_next = 16'd0;
                xor_next    = 8'd0;
            end else begin
                remain_next = remain_dec;
                xor_next    = pay_x;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg   <= 1'b0;
            remain_reg <= 16'd0;
            xor_reg    <= 8'd0;
        end else if (q_push) begin
            open_reg   <= open_next;
            remain_reg <= remain_next;
            xor_reg    <= xor_next;
        end
    end

endmodule

// File: src/tfb_queue.sv
// ============================================================================
// tfb_queue
// Short command queue between the front and the back end.
// ============================================================================
module tfb_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  tfb_pkg::tfb_cmd_t push_cmd,
    output logic              push_ready,
    input  logic              pop,
    output logic              pop_valid,
    output tfb_pkg::tfb_cmd_t pop_cmd
);
    import tfb_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    tfb_cmd_t        entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: src/tfb_back.sv
// ============================================================================
// tfb_back
// Sequences the bytes of each command into the output register.
// ============================================================================
module tfb_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [63:0]       station_address,
    input  logic              q_valid,
    input  tfb_pkg::tfb_cmd_t q_cmd,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output tfb_pkg::tfb_out_t m_data
);
    import tfb_pkg::*;

    tfb_cmd_t   cur_reg;
    logic       cur_valid_reg;
    logic [3:0] step_reg;
    tfb_out_t   out_reg, out_next;
    logic       out_valid_reg;

    logic       adv;
    logic       cur_last;
    logic [3:0] n_body;
    logic [3:0] addr_bytes;
    logic [3:0] addr_off;
    logic [3:0] tail_off;
    logic [7:0] body_byte;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;
    assign adv     = !out_valid_reg || m_ready;

    always_comb begin
        addr_bytes = cur_reg.fmt ? 4'd8 : 4'd4;
        case (cur_reg.kind)
            CMD_HEADER: n_body = cur_reg.fmt ? HDR_BYTES_FMT1 : HDR_BYTES_FMT0;
            default:    n_body = 4'd1;
        endcase
        cur_last = cur_reg.trailer ? (step_reg == n_body + 4'd1)
                                   : (step_reg == n_body - 4'd1);
        addr_off = step_reg - ADDR_START;
        tail_off = step_reg - (ADDR_START + addr_bytes);

        body_byte = 8'd0;
        case (cur_reg.kind)
            CMD_HEADER: begin
                if (step_reg == 4'd0) begin
                    body_byte = FLAG_BYTE;
                end else if (step_reg == 4'd1) begin
                    body_byte = cur_reg.fmt ? VER_FMT1 : VER_FMT0;
                end else if (addr_off < addr_bytes) begin
                    body_byte = station_address[{addr_off[2:0], 3'b000} +: 8];
                end else begin
                    case (tail_off[1:0])
                        2'd0:    body_byte = cur_reg.command_id[15:8];
                        2'd1:    body_byte = cur_reg.command_id[7:0];
                        2'd2:    body_byte = cur_reg.payload_length[15:8];
                        default: body_byte = cur_reg.payload_length[7:0];
                    endcase
                end
            end
            CMD_PAYLOAD: body_byte = cur_reg.data_byte;
            default:     body_byte = 8'd0;
        endcase

        out_next           = out_reg;
        out_next.run_last  = cur_last;
        out_next.status    = cur_reg.status;
        out_next.frame_end = 1'b0;
        if (step_reg < n_body) begin
            out_next.frame_byte = body_byte;
        end else if (step_reg == n_body) begin
            out_next.frame_byte = cur_reg.checksum;
        end else begin
            out_next.frame_byte = END_BYTE;
            out_next.frame_end  = 1'b1;
        end

        q_pop = q_valid && (!cur_valid_reg || (adv && cur_last));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            step_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (adv) begin
                out_valid_reg <= cur_valid_reg;
            end
            if (q_pop) begin
                cur_valid_reg <= 1'b1;
                step_reg      <= 4'd0;
            end else if (adv && cur_valid_reg) begin
                if (cur_last) begin
                    cur_valid_reg <= 1'b0;
                end else begin
                    step_reg <= step_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_cmd;
        end
        if (adv && cur_valid_reg) begin
            out_reg <= out_next;
        end
    end

endmodule

// File: src/telemetry_frame_builder.sv
// ============================================================================
// telemetry_frame_builder
// Builds outgoing link frames byte by byte: header on a start word, payload
// pass-through, checksum and closing byte after the last payload byte.
// ============================================================================
//
//  Channel   Direction  Handshake            Word
//  s_        in         s_valid / s_ready    tfb_in_t  (action, id, length, data)
//  m_        out        m_valid / m_ready    tfb_out_t (byte, run_last, end, status)
//  cfg_      in         cfg_valid/cfg_ready  cfg_index (0 format, 1 address), cfg_data
//
//  While m_ready is high, payload words sustain one word per cycle in and one
//  byte per cycle out; a start word yields 10 or 14 header bytes (plus 2 trailer bytes
//  when the length is zero), one per cycle; the back-end byte sequencer sets this.
//  The front keeps accepting while the command queue has room, so a header
//  burst is absorbed by the queue of QUEUE_DEPTH words and the sequencer.
//  An accepted word reaches m_data through the queue, command and output registers.
//  Reset is synchronous; it clears frame state, queue, sequencer and sets
//  frame_format to 1 and station_address to 0.
//  m_ready low holds the output byte; the queue then fills and drops s_ready.
//
module telemetry_frame_builder #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  tfb_pkg::tfb_in_t                    s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output tfb_pkg::tfb_out_t                   m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tfb_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [63:0]                         cfg_data
);
    import tfb_pkg::*;

    logic        format_reg;
    logic [63:0] address_reg;

    logic        q_ready;
    logic        q_push;
    tfb_cmd_t    push_cmd;
    logic        q_valid;
    logic        q_pop;
    tfb_cmd_t    pop_cmd;

    // Configuration is always taken; the host must write only while no word is in
    // flight so no write lands in the middle of a header; not enforced by the block
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            format_reg  <= 1'b1;
            address_reg <= 64'd0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_FORMAT:  format_reg  <= cfg_data[0];
                CFG_ADDRESS: address_reg <= cfg_data;
                default:     ;   // drop writes to unknown indexes
            endcase
        end
    end

    // Front: classify words, advance frame state and checksum
    tfb_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .frame_format    (format_reg),
        .station_address (address_reg),
        .q_ready         (q_ready),
        .q_push          (q_push),
        .q_cmd           (push_cmd)
    );

    // Queue: decouple the front from the byte sequencer
    tfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (push_cmd),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_cmd    (pop_cmd)
    );

    // Back: emit the bytes of each command into the output register
    tfb_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .station_address (address_reg),
        .q_valid         (q_valid),
        .q_cmd           (pop_cmd),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data)
    );

endmodule

// File: verif/telemetry_frame_builder_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// telemetry_frame_builder_tb
// Self-checking bench: drives start and payload words, predicts every frame
// byte in a scoreboard and checks the output stream in order under stalls.
// ============================================================================
module telemetry_frame_builder_tb;
    import tfb_pkg::*;

    localparam int CLK_HALF_NS   = 4;
    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 4;     // margin for the block's pipeline to drain
    localparam int STALL_LIMIT   = 3000;  // cycles with no handshake at all
    localparam int HOLD_CYCLES   = 80;    // long receiver hold-off
    localparam int NUM_PHASES    = 6;
    localparam int PHASE_WORDS   = 40;
    localparam int REPORT_MAX    = 10;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the frame state and the queue of bytes owed
    // ------------------------------------------------------------------------
    class frame_scoreboard;
        bit          fmt;
        logic [63:0] station;
        bit          open;
        logic [15:0] left;
        logic [7:0]  sum_acc;
        tfb_out_t    wire_bytes_q[$];
        int          mismatches;
        int          checked;

        function new();
            fmt        = 1'b1;
            station    = '0;
            open       = 1'b0;
            left       = '0;
            sum_acc    = '0;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [63:0] val);
            if (idx == CFG_FORMAT) begin
                fmt = val[0];
            end else if (idx == CFG_ADDRESS) begin
                station = val;
            end
        endfunction

        function void push_byte(logic [7:0] b, logic [1:0] st, bit counted, bit closing);
            tfb_out_t w;
            w.frame_byte = b;
            w.run_last   = 1'b0;
            w.frame_end  = closing;
            w.status     = st;
            wire_bytes_q.push_back(w);
            if (counted) begin
                sum_acc = sum_acc ^ b;
            end
        endfunction

        // Checksum byte, then the closing byte; the frame is done after this
        function void push_trailer(logic [1:0] st);
            logic [7:0] c;
            c = sum_acc + 8'd1;
            if (c == 8'h00 || c == FLAG_BYTE || c == 8'h08 || c == 8'h0a ||
                c == END_BYTE || c == 8'h22) begin
                c = c + SUM_BUMP;
            end
            push_byte(c, st, 1'b0, 1'b0);
            push_byte(END_BYTE, st, 1'b0, 1'b1);
            open    = 1'b0;
            left    = '0;
            sum_acc = '0;
        endfunction

        function void note_word(tfb_in_t w);
            logic [1:0] st;
            tfb_out_t   last;
            if (w.action == ACT_START) begin
                st      = open ? ST_ABORTED : ST_OK;
                sum_acc = '0;
                push_byte(FLAG_BYTE, st, 1'b0, 1'b0);
                push_byte(fmt ? VER_FMT1 : VER_FMT0, st, 1'b1, 1'b0);
                for (int i = 0; i < (fmt ? 8 : 4); i++) begin
                    push_byte(station[8*i +: 8], st, 1'b1, 1'b0);
                end
                push_byte(w.command_id[15:8], st, 1'b1, 1'b0);
                push_byte(w.command_id[7:0], st, 1'b1, 1'b0);
                push_byte(w.payload_length[15:8], st, 1'b1, 1'b0);
                push_byte(w.payload_length[7:0], st, 1'b1, 1'b0);
                open = 1'b1;
                left = w.payload_length;
                if (w.payload_length == 16'd0) begin
                    push_trailer(st);
                end
            end else if (!open) begin
                push_byte(8'h00, ST_DROPPED, 1'b0, 1'b0);
            end else begin
                push_byte(w.data_byte, ST_OK, 1'b1, 1'b0);
                left = left - 16'd1;
                if (left == 16'd0) begin
                    push_trailer(ST_OK);
                end
            end
            last = wire_bytes_q.pop_back();
            last.run_last = 1'b1;
            wire_bytes_q.push_back(last);
        endfunction

        function void check_byte(tfb_out_t got);
            tfb_out_t want;
            checked++;
            if (wire_bytes_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("byte %0d unexpected: got byte %02h last %0b end %0b st %0d",
                             checked, got.frame_byte, got.run_last, got.frame_end,
                             got.status);
                end
            end else begin
                want = wire_bytes_q.pop_front();
                if (got.frame_byte !== want.frame_byte || got.run_last !== want.run_last ||
                    got.frame_end !== want.frame_end || got.status !== want.status) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("byte %0d mismatch: want %02h/%0b/%0b/%0d got %02h/%0b/%0b/%0d",
                                 checked, want.frame_byte, want.run_last, want.frame_end,
                                 want.status, got.frame_byte, got.run_last, got.frame_end,
                                 got.status);
                    end
                end
            end
        endfunction

        function int outstanding();
            return wire_bytes_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, DUT ports and instance
    // ------------------------------------------------------------------------
    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    tfb_in_t                s_data;
    logic                   m_valid;
    logic                   m_ready;
    tfb_out_t               m_data;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [63:0]            cfg_data;

    always #(CLK_HALF_NS) aclk = ~aclk;

    telemetry_frame_builder u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    frame_scoreboard frames;

    // Shared knobs between the stimulus and the receiver process
    int       rx_mode;       // 0 always ready, 1 light random, 2 pattern, 3 heavy
    bit [7:0] rx_pattern;
    bit       hold_req;      // ask the receiver for one long hold-off
    bit       gaps_on;       // sender inserts idle gaps between bursts
    int       burst_left;
    int       words_sent;

    // ------------------------------------------------------------------------
    // Output monitor: every accepted byte goes to the scoreboard
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            frames.check_byte(m_data);
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: drive m_ready on the falling edge by the current stall mode.
    // A hold request drops m_ready for a long stretch counted right here, so
    // the queue inside the block fills and s_ready goes low.
    // ------------------------------------------------------------------------
    initial begin : rx_stall
        int tick;
        tick    = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                case (rx_mode)
                    0: begin
                        m_ready <= 1'b1;
                    end
                    1: begin
                        m_ready <= ($urandom_range(0, 3) != 0);
                    end
                    2: begin
                        m_ready <= rx_pattern[tick[2:0]];
                        tick++;
                    end
                    default: begin
                        m_ready <= ($urandom_range(0, 3) == 0);
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if no channel moves a word for too long
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
                (cfg_valid && cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("[telemetry_frame_builder] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------
    function automatic tfb_in_t make_start(logic [15:0] cid, logic [15:0] len);
        tfb_in_t w;
        w.action         = ACT_START;
        w.command_id     = cid;
        w.payload_length = len;
        w.data_byte      = 8'($urandom_range(0, 255));   // ignored on start
        return w;
    endfunction

    function automatic tfb_in_t make_data(logic [7:0] b);
        tfb_in_t w;
        w.action         = ACT_DATA;
        w.command_id     = 16'($urandom_range(0, 65535)); // ignored on payload
        w.payload_length = 16'($urandom_range(0, 65535));
        w.data_byte      = b;
        return w;
    endfunction

    // Offer one word; open a new burst with an optional gap when the last
    // one ran out. Hold valid and payload until the handshake.
    task automatic send_word(input tfb_in_t w);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (gaps_on) begin
                gap = $urandom_range(0, 6);
            end
        end
        burst_left--;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        frames.note_word(w);
        words_sent++;
    endtask

    task automatic idle_input();
        @(negedge aclk);
        s_valid    <= 1'b0;
        burst_left = 0;
    endtask

    // Pause the sender until every owed byte is out, then let the pipe settle
    task automatic drain();
        idle_input();
        while (frames.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        frames.set_reg(idx, val);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // One random stretch of traffic: mostly complete frames with random
    // content, some stray payload words, some frames left open to be aborted
    task automatic send_random_run();
        int          pick;
        int          n;
        logic [15:0] len;
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
            len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(7, 40))
                                              : 16'($urandom_range(0, 6));
            send_word(make_start(16'($urandom_range(0, 65535)), len));
            for (int i = 0; i < len; i++) begin
                send_word(make_data(8'($urandom_range(0, 255))));
            end
        end else if (pick < 88) begin
            send_word(make_data(8'($urandom_range(0, 255))));
        end else begin
            // wide length so the next start abandons this frame
            len = 16'($urandom_range(8, 65535));
            n   = $urandom_range(0, 3);
            send_word(make_start(16'($urandom_range(0, 65535)), len));
            for (int i = 0; i < n; i++) begin
                send_word(make_data(8'($urandom_range(0, 255))));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [7:0]  bump_hits [6];
        logic [63:0] addr;
        int          target;

        frames     = new();
        bump_hits  = '{8'h00, FLAG_BYTE, 8'h08, 8'h0a, END_BYTE, 8'h22};
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        rx_mode    = 1;
        rx_pattern = 8'b1011_0111;
        hold_req   = 1'b0;
        gaps_on    = 1'b1;
        burst_left = 0;
        words_sent = 0;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part, reset register values first: stray payload words,
        // zero-length frame, short frame with extreme bytes, abort
        send_word(make_data(8'hff));
        send_word(make_data(8'h00));
        send_word(make_start(16'hffff, 16'd0));
        send_word(make_start(16'h0000, 16'd2));
        send_word(make_data(8'h00));
        send_word(make_data(8'hff));
        send_word(make_start(16'h1234, 16'hffff));
        send_word(make_start(16'habcd, 16'd1));
        send_word(make_data(8'h5a));

        // Short header, all-ones address; switch format with a frame open
        drain();
        write_reg(CFG_FORMAT, 64'd0);
        write_reg(CFG_ADDRESS, '1);
        send_word(make_start(16'h00ff, 16'd0));
        send_word(make_start(16'hff00, 16'd3));
        send_word(make_data(8'h11));
        drain();
        write_reg(CFG_FORMAT, 64'd1);
        send_word(make_data(8'h22));
        send_word(make_data(8'h33));

        // Steer the checksum onto each reserved value so it gets bumped
        foreach (bump_hits[i]) begin
            send_word(make_start(16'($urandom_range(0, 65535)), 16'd1));
            send_word(make_data(frames.sum_acc ^ (bump_hits[i] - 8'd1)));
        end

        // Random phases, each with its own register and stall settings
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            case (p % 3)
                0: addr = {$urandom, $urandom};
                1: addr = '0;
                default: addr = '1;
            endcase
            write_reg(CFG_FORMAT, 64'(p % 2));
            write_reg(CFG_ADDRESS, addr);
            rx_mode    = p % 4;
            rx_pattern = 8'($urandom_range(1, 255));
            // back-to-back offers in two phases; the first of them also
            // gets the long receiver hold-off so the input backs up
            gaps_on  = (p != 2 && p != 3);
            hold_req = (p == 2);
            target   = words_sent + PHASE_WORDS;
            while (words_sent < target) begin
                send_random_run();
            end
        end

        // Wrap up: wait for every owed byte, then watch for strays
        idle_input();
        while (frames.outstanding() != 0) @(posedge aclk);
        repeat (2 * SETTLE_CYCLES) @(posedge aclk);
        if (frames.mismatches == 0 && frames.outstanding() == 0) begin
            $display("[telemetry_frame_builder] OK");
        end else begin
            $display("[telemetry_frame_builder] ERROR");
        end
        $finish;
    end

endmodule
